// ----- rtl/word_hash_distinct_counter_macros.svh -----
// assertion helpers shared by the rtl files
`ifndef WORD_HASH_DISTINCT_COUNTER_MACROS_SVH
`define WORD_HASH_DISTINCT_COUNTER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked on every rising edge outside reset
`define WHDC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("whdc check failed");
// next-cycle implication
`define WHDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("whdc check failed");
`else
`define WHDC_ASSERT_IMPL(lbl, ante, cons)
`define WHDC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/whdc_pkg.sv -----
package whdc_pkg;

  localparam logic [7:0]  SEP_BYTE = 8'h20;
  localparam logic [31:0] MM_C1    = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2    = 32'h1b873593;
  localparam logic [31:0] FMIX_C1  = 32'h85ebca6b;
  localparam logic [31:0] FMIX_C2  = 32'hc2b2ae35;
  localparam logic [31:0] MIX_ADD  = 32'he6546b64;

  // bitmap rows are 32 bits wide
  localparam int ROW_BITS  = 5;
  localparam int ROW_WIDTH = 32;
  localparam int COUNT_W   = 17;

  typedef logic [3:0] op_t;

  localparam op_t OP_NONE       = 4'd0;
  localparam op_t OP_CLEAR_ROW  = 4'd1;
  localparam op_t OP_ACCEPT     = 4'd2;
  localparam op_t OP_MUL_C2     = 4'd3;
  localparam op_t OP_ROUND      = 4'd4;
  localparam op_t OP_TAIL       = 4'd5;
  localparam op_t OP_FMIX0      = 4'd6;
  localparam op_t OP_FMIX1      = 4'd7;
  localparam op_t OP_FMIX2      = 4'd8;
  localparam op_t OP_EMIT       = 4'd9;
  localparam op_t OP_EMIT_EMPTY = 4'd10;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic in_space;   // offered byte is a separator
    logic in_last;    // offered byte ends the stream
    logic fill3;      // partial block holds three bytes
    logic fill_zero;  // no partial block bytes
    logic len_zero;   // no pending word
    logic last;       // captured stream end flag
    logic clr_last;   // clearing pass at final row
    logic out_free;   // output register can take a result
  } status_t;

endpackage

// ----- rtl/whdc_if.sv -----
interface whdc_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       stream_end;

  modport source (output valid, text_byte, stream_end, input ready);
  modport sink   (input valid, text_byte, stream_end, output ready);
endinterface

interface whdc_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] word_hash;
  logic        word_present;
  logic        is_new;
  logic [16:0] distinct_count;
  logic        stream_done;

  modport source (output valid, word_hash, word_present, is_new, distinct_count,
                  stream_done, input ready);
  modport sink   (input valid, word_hash, word_present, is_new, distinct_count,
                  stream_done, output ready);
endinterface

// ----- rtl/word_hash_distinct_counter.sv -----
// word_hash_distinct_counter: distinct word estimator over a byte stream
// text channel: one byte per transaction, stream_end marks the last byte;
//   bytes other than 0x20 build a word, 0x20 closes it
// result channel: one transaction per finished non-empty word, plus one
//   empty-word transaction when the stream ends with no word pending
// per byte: a byte that does not complete a 4-byte block is taken alone;
//   one that does also takes two passes through the shared multiplier
//   plus the round update before the next byte is taken
// word end: after the closing transaction the result reaches the output
//   register through an optional two-step tail scramble, two final mix
//   multiplies, the last mix step with the bitmap row read, then the
//   read-modify-write; the empty-word transaction is emitted directly
// the bitmap sits in a ram of 32-bit rows; after reset a clearing pass
//   zeroes all 2**(HASH_BITS-5) rows (2048 at the default) before the
//   first byte is taken; count and word state also clear at reset
// the result waits in an output register, so bytes keep flowing while the
//   receiver stalls, until the next result is ready: then the block holds
//   text ready low until the register frees up
module word_hash_distinct_counter #(
  parameter int HASH_BITS = 16
) (
  input logic          clk,
  input logic          rst,
  whdc_text_if.sink    text,
  whdc_result_if.source result
);

  whdc_pkg::cmd_t    cmd;
  whdc_pkg::status_t st;
  logic              ready;

  // handshake on the text side is owned by the controller
  assign text.ready = ready;

  whdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (text.valid),
    .in_ready (ready),
    .st       (st),
    .cmd      (cmd)
  );

  // hashing, bitmap ram and output register
  whdc_datapath #(
    .HASH_BITS (HASH_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .text_byte   (text.text_byte),
    .stream_end  (text.stream_end),
    .out_ready   (result.ready),
    .out_valid   (result.valid),
    .out_hash    (result.word_hash),
    .out_present (result.word_present),
    .out_is_new  (result.is_new),
    .out_count   (result.distinct_count),
    .out_done    (result.stream_done)
  );

endmodule

// ----- rtl/whdc_ram.sv -----
module whdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/whdc_datapath.sv -----
`include "word_hash_distinct_counter_macros.svh"

module whdc_datapath #(
  parameter int HASH_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  whdc_pkg::cmd_t               cmd,
  output whdc_pkg::status_t            st,
  input  logic [7:0]                   text_byte,
  input  logic                         stream_end,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [31:0]                  out_hash,
  output logic                         out_present,
  output logic                         out_is_new,
  output logic [whdc_pkg::COUNT_W-1:0] out_count,
  output logic                         out_done
);

  localparam int ROWS = 2 ** (HASH_BITS - whdc_pkg::ROW_BITS);
  localparam int AW   = HASH_BITS - whdc_pkg::ROW_BITS;

  // word state
  logic [31:0] rh;
  logic [23:0] pblk;
  logic [1:0]  fill;
  logic [31:0] len;
  logic        last_r;

  // mixing scratch and finished hash
  logic [31:0] acc;
  logic [31:0] hash_r;

  logic [AW-1:0]                  clr_addr;
  logic [whdc_pkg::COUNT_W-1:0]   count;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] prod;
  logic [31:0] h0;
  logic [31:0] fin;
  logic [31:0] mixed;
  logic [23:0] pblk_ins;

  logic                            ram_wr_en;
  logic [AW-1:0]                   ram_wr_addr;
  logic [whdc_pkg::ROW_WIDTH-1:0]  ram_wr_data;
  logic                            ram_rd_en;
  logic [whdc_pkg::ROW_WIDTH-1:0]  ram_rd_data;
  logic                            hit;
  logic [whdc_pkg::ROW_WIDTH-1:0]  bit_mask;

  assign h0       = rh ^ ((fill != 2'd0) ? acc : 32'd0) ^ len;
  assign fin      = acc ^ {16'd0, acc[31:16]};
  assign mixed    = {rh[18:0] ^ acc[18:0], rh[31:19] ^ acc[31:19]};
  assign pblk_ins = 24'({16'd0, text_byte} << {fill, 3'b000});
  assign bit_mask = whdc_pkg::ROW_WIDTH'(1) << hash_r[whdc_pkg::ROW_BITS-1:0];
  assign hit      = ram_rd_data[hash_r[whdc_pkg::ROW_BITS-1:0]];

  // one shared 32x32 multiplier, low word kept
  always_comb begin
    case (cmd.op)
      whdc_pkg::OP_ACCEPT: begin
        mul_a = {text_byte, pblk};
        mul_b = whdc_pkg::MM_C1;
      end
      whdc_pkg::OP_MUL_C2: begin
        mul_a = {acc[16:0], acc[31:17]};
        mul_b = whdc_pkg::MM_C2;
      end
      whdc_pkg::OP_TAIL: begin
        mul_a = {8'd0, pblk};
        mul_b = whdc_pkg::MM_C1;
      end
      whdc_pkg::OP_FMIX0: begin
        mul_a = h0 ^ {16'd0, h0[31:16]};
        mul_b = whdc_pkg::FMIX_C1;
      end
      whdc_pkg::OP_FMIX1: begin
        mul_a = acc ^ {13'd0, acc[31:13]};
        mul_b = whdc_pkg::FMIX_C2;
      end
      default: begin
        mul_a = acc;
        mul_b = 32'd0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = hash_r[HASH_BITS-1:whdc_pkg::ROW_BITS];
    ram_wr_data = ram_rd_data | bit_mask;
    ram_rd_en   = 1'b0;
    case (cmd.op)
      whdc_pkg::OP_CLEAR_ROW: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr;
        ram_wr_data = '0;
      end
      whdc_pkg::OP_FMIX2: begin
        ram_rd_en = 1'b1;
      end
      whdc_pkg::OP_EMIT: begin
        ram_wr_en = !hit;
      end
      default: begin
        ram_wr_en = 1'b0;
      end
    endcase
  end

  whdc_ram #(
    .WIDTH (whdc_pkg::ROW_WIDTH),
    .DEPTH (ROWS)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (fin[HASH_BITS-1:whdc_pkg::ROW_BITS]),
    .rd_data (ram_rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rh        <= '0;
      pblk      <= '0;
      fill      <= '0;
      len       <= '0;
      clr_addr  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == whdc_pkg::OP_EMIT || cmd.op == whdc_pkg::OP_EMIT_EMPTY) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        whdc_pkg::OP_CLEAR_ROW: begin
          clr_addr <= clr_addr + AW'(1);
        end
        whdc_pkg::OP_ACCEPT: begin
          if (text_byte != whdc_pkg::SEP_BYTE) begin
            len <= len + 32'd1;
            if (fill == 2'd3) begin
              pblk <= '0;
              fill <= 2'd0;
            end else begin
              pblk <= pblk | pblk_ins;
              fill <= fill + 2'd1;
            end
          end
        end
        whdc_pkg::OP_ROUND: begin
          rh <= {mixed[29:0], 2'b00} + mixed + whdc_pkg::MIX_ADD;
        end
        whdc_pkg::OP_EMIT: begin
          if (!hit) begin
            count <= count + whdc_pkg::COUNT_W'(1);
          end
          rh        <= '0;
          pblk      <= '0;
          fill      <= '0;
          len       <= '0;
        end
        whdc_pkg::OP_EMIT_EMPTY: begin
          rh        <= '0;
          pblk      <= '0;
          fill      <= '0;
          len       <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      whdc_pkg::OP_ACCEPT: begin
        last_r <= stream_end;
        acc    <= prod;
      end
      whdc_pkg::OP_MUL_C2, whdc_pkg::OP_TAIL, whdc_pkg::OP_FMIX0, whdc_pkg::OP_FMIX1: begin
        acc <= prod;
      end
      whdc_pkg::OP_FMIX2: begin
        hash_r <= fin;
      end
      whdc_pkg::OP_EMIT: begin
        out_hash    <= hash_r;
        out_present <= 1'b1;
        out_is_new  <= !hit;
        out_count   <= hit ? count : count + whdc_pkg::COUNT_W'(1);
        out_done    <= last_r;
      end
      whdc_pkg::OP_EMIT_EMPTY: begin
        out_hash    <= '0;
        out_present <= 1'b0;
        out_is_new  <= 1'b0;
        out_count   <= count;
        out_done    <= 1'b1;
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  always_comb begin
    st.in_space  = text_byte == whdc_pkg::SEP_BYTE;
    st.in_last   = stream_end;
    st.fill3     = fill == 2'd3;
    st.fill_zero = fill == 2'd0;
    st.len_zero  = len == 32'd0;
    st.last      = last_r;
    st.clr_last  = clr_addr == '1;
    st.out_free  = !out_valid || out_ready;
  end

  `WHDC_ASSERT_NEXT(a_count_step, !rst, count == $past(count) || count == $past(count) + 17'd1)
  `WHDC_ASSERT_IMPL(a_new_is_word, out_valid && out_is_new, out_present)
  `WHDC_ASSERT_IMPL(a_fill_has_len, fill != 2'd0, len != 32'd0)

endmodule

// ----- rtl/whdc_ctrl.sv -----
`include "word_hash_distinct_counter_macros.svh"

module whdc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  whdc_pkg::status_t st,
  output whdc_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCR2  = 4'd2;
  localparam logic [3:0] S_SCR3  = 4'd3;
  localparam logic [3:0] S_TAIL1 = 4'd4;
  localparam logic [3:0] S_TAIL2 = 4'd5;
  localparam logic [3:0] S_FMIX0 = 4'd6;
  localparam logic [3:0] S_FMIX1 = 4'd7;
  localparam logic [3:0] S_FMIX2 = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_EMPTY = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd.op     = whdc_pkg::OP_NONE;
    case (state)
      S_CLEAR: begin
        cmd.op = whdc_pkg::OP_CLEAR_ROW;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = whdc_pkg::OP_ACCEPT;
          if (!st.in_space) begin
            if (st.fill3) begin
              state_next = S_SCR2;
            end else if (st.in_last) begin
              state_next = S_TAIL1;
            end
          end else if (!st.len_zero) begin
            state_next = st.fill_zero ? S_FMIX0 : S_TAIL1;
          end else if (st.in_last) begin
            state_next = S_EMPTY;
          end
        end
      end
      S_SCR2: begin
        cmd.op     = whdc_pkg::OP_MUL_C2;
        state_next = S_SCR3;
      end
      S_SCR3: begin
        cmd.op     = whdc_pkg::OP_ROUND;
        state_next = st.last ? S_FMIX0 : S_IDLE;
      end
      S_TAIL1: begin
        cmd.op     = whdc_pkg::OP_TAIL;
        state_next = S_TAIL2;
      end
      S_TAIL2: begin
        cmd.op     = whdc_pkg::OP_MUL_C2;
        state_next = S_FMIX0;
      end
      S_FMIX0: begin
        cmd.op     = whdc_pkg::OP_FMIX0;
        state_next = S_FMIX1;
      end
      S_FMIX1: begin
        cmd.op     = whdc_pkg::OP_FMIX1;
        state_next = S_FMIX2;
      end
      S_FMIX2: begin
        cmd.op     = whdc_pkg::OP_FMIX2;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.op     = whdc_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (st.out_free) begin
          cmd.op     = whdc_pkg::OP_EMIT_EMPTY;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  `WHDC_ASSERT_NEXT(a_clear_ends, state == S_CLEAR && st.clr_last, state == S_IDLE)
  `WHDC_ASSERT_IMPL(a_emit_free, cmd.op == whdc_pkg::OP_EMIT, st.out_free)
  `WHDC_ASSERT_IMPL(a_round_from_accept, state == S_SCR2, $past(state) == S_IDLE)

endmodule
